/* rtl/core/hppj_pkg.sv */
// Shared types, constants and helpers for the homography point projection block.
package hppj_pkg;

  localparam int WORD_BITS  = 32;
  localparam int FRAC_BITS  = 16;
  localparam int PROD_W     = 2 * WORD_BITS;
  localparam int PSUM_W     = PROD_W - FRAC_BITS + 2;
  localparam int DEN_W      = PSUM_W - 1;
  localparam int PHI_W      = DEN_W - WORD_BITS;
  localparam int NUM_W      = DEN_W + WORD_BITS;
  localparam int DIV_LAT    = WORD_BITS + 1;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int NA         = 5;
  localparam int NB         = 6;

  localparam logic [CFG_IDX_W-1:0] REG_H00_H01      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_H02_H10      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_H11_H12      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_H20_H21      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_H22_SCALE_IN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_OUT    = 3'd5;

  localparam logic [CFG_DATA_W-1:0] RST_H00_H01      = 64'h0001_0000_0000_0000;
  localparam logic [CFG_DATA_W-1:0] RST_H02_H10      = 64'h0;
  localparam logic [CFG_DATA_W-1:0] RST_H11_H12      = 64'h0001_0000_0000_0000;
  localparam logic [CFG_DATA_W-1:0] RST_H20_H21      = 64'h0;
  localparam logic [CFG_DATA_W-1:0] RST_H22_SCALE_IN = 64'h0001_0000_0001_0000;
  localparam logic [WORD_BITS-1:0]  RST_SCALE_OUT    = 32'h0001_0000;

  typedef logic signed [WORD_BITS-1:0] word_t;

  typedef struct packed {
    word_t point_x;
    word_t point_y;
  } in_item_t;

  typedef struct packed {
    word_t proj_u;
    word_t proj_v;
    word_t jac_xs;
    word_t jac_ys;
    word_t jac_hs;
    word_t jac_xu;
    word_t jac_yu;
    word_t jac_hu;
    word_t jac_xv;
    word_t jac_yv;
    word_t jac_hv;
    logic  divide_fault;
  } out_item_t;

  typedef struct packed {
    word_t h00, h01, h02;
    word_t h10, h11, h12;
    word_t h20, h21, h22;
    word_t zh1;
    word_t zh2;
  } hom_t;

  typedef struct packed {
    logic                     valid;
    logic                     fault;
    word_t                    x;
    word_t                    y;
    logic signed [PSUM_W-1:0] p0;
    logic signed [PSUM_W-1:0] p1;
    logic signed [PSUM_W-1:0] w;
  } proj_out_t;

  // sideband alongside the first divider bank
  typedef struct packed {
    logic             valid;
    logic             fault;
    logic             wneg;
    logic [NA-1:0]    sgn;
    word_t            x;
    word_t            y;
    logic [DEN_W-1:0] den;
  } sb_a_t;

  // sideband alongside the second divider bank
  typedef struct packed {
    logic          valid;
    logic          fault;
    logic [NB-1:0] sgn;
    word_t         u;
    word_t         v;
    word_t         xs;
    word_t         ys;
    word_t         hs;
  } sb_b_t;

  function automatic logic [WORD_BITS-1:0] mag_w(input word_t a);
    logic [WORD_BITS-1:0] r;
    r = a[WORD_BITS-1] ? (~a + 1'b1) : a;
    return r;
  endfunction

  function automatic logic signed [PROD_W-1:0] smul(input word_t a, input word_t b);
    logic signed [PROD_W-1:0] ea;
    logic signed [PROD_W-1:0] eb;
    ea = {{WORD_BITS{a[WORD_BITS-1]}}, a};
    eb = {{WORD_BITS{b[WORD_BITS-1]}}, b};
    return ea * eb;
  endfunction

  // saturate a truncated quotient magnitude and apply the sign
  function automatic word_t sat_q(input logic [WORD_BITS-1:0] q, input logic ovf,
                                  input logic s);
    logic [WORD_BITS-1:0] lim;
    logic [WORD_BITS-1:0] qq;
    lim = {1'b0, {(WORD_BITS-1){1'b1}}} + {{(WORD_BITS-1){1'b0}}, s};
    qq  = (ovf || q > lim) ? lim : q;
    return s ? word_t'(~qq + 1'b1) : word_t'(qq);
  endfunction

endpackage

/* rtl/core/homography_point_project_jacobian.sv */
// Projects one Q16.16 point per clock (while in_stall is low) through the configured homography
// and returns (u, v) with nine Jacobian terms, computed by two 33-stage restoring divider banks
// (an overflow check, then one quotient bit per stage) in series, the second fed by the saturated
// u and v of the first; a two-entry output buffer lets input flow while a result waits.
module homography_point_project_jacobian (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  hppj_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output hppj_pkg::out_item_t               out_data,
  input  logic                              cfg_we,
  input  logic [hppj_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [hppj_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import hppj_pkg::*;

  logic [CFG_DATA_W-1:0] h00_h01_r, h02_h10_r, h11_h12_r, h20_h21_r, h22_scale_in_r;
  logic [WORD_BITS-1:0]  scale_out_r;
  hom_t                  hom;
  logic                  en;
  proj_out_t             po;

  // ---- configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h00_h01_r      <= RST_H00_H01;
      h02_h10_r      <= RST_H02_H10;
      h11_h12_r      <= RST_H11_H12;
      h20_h21_r      <= RST_H20_H21;
      h22_scale_in_r <= RST_H22_SCALE_IN;
      scale_out_r    <= RST_SCALE_OUT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_H00_H01:      h00_h01_r      <= cfg_wdata;
        REG_H02_H10:      h02_h10_r      <= cfg_wdata;
        REG_H11_H12:      h11_h12_r      <= cfg_wdata;
        REG_H20_H21:      h20_h21_r      <= cfg_wdata;
        REG_H22_SCALE_IN: h22_scale_in_r <= cfg_wdata;
        REG_SCALE_OUT:    scale_out_r    <= cfg_wdata[WORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    hom.h00 = h00_h01_r[63:32];
    hom.h01 = h00_h01_r[31:0];
    hom.h02 = h02_h10_r[63:32];
    hom.h10 = h02_h10_r[31:0];
    hom.h11 = h11_h12_r[63:32];
    hom.h12 = h11_h12_r[31:0];
    hom.h20 = h20_h21_r[63:32];
    hom.h21 = h20_h21_r[31:0];
    hom.h22 = h22_scale_in_r[63:32];
    hom.zh1 = h22_scale_in_r[31:0];
    hom.zh2 = scale_out_r;
  end

  hppj_proj u_proj (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (in_valid),
    .in_data  (in_data),
    .hom      (hom),
    .po       (po)
  );

  // ---- A1: numerator partial products (p0, p1 split into low word and high part)
  logic [DEN_W-1:0]     pm0, pm1, wm;
  logic [WORD_BITS-1:0] zm;
  logic [PROD_W-1:0]    plo_r [2];
  logic [DEN_W-1:0]     phi_r [2];
  logic [PROD_W-1:0]    nxa_r [3];
  sb_a_t                a1_r;
  logic                 zneg, wneg_a;

  always_comb begin
    pm0    = po.p0[PSUM_W-1] ? DEN_W'(-po.p0) : DEN_W'(po.p0);
    pm1    = po.p1[PSUM_W-1] ? DEN_W'(-po.p1) : DEN_W'(po.p1);
    wm     = po.w[PSUM_W-1]  ? DEN_W'(-po.w)  : DEN_W'(po.w);
    zm     = mag_w(hom.zh2);
    zneg   = hom.zh2[WORD_BITS-1];
    wneg_a = po.w[PSUM_W-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) a1_r.valid <= 1'b0;
    else if (en) a1_r.valid <= po.valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      plo_r[0] <= PROD_W'(pm0[WORD_BITS-1:0]) * PROD_W'(zm);
      plo_r[1] <= PROD_W'(pm1[WORD_BITS-1:0]) * PROD_W'(zm);
      phi_r[0] <= DEN_W'(pm0[DEN_W-1:WORD_BITS]) * DEN_W'(zm);
      phi_r[1] <= DEN_W'(pm1[DEN_W-1:WORD_BITS]) * DEN_W'(zm);
      nxa_r[0] <= PROD_W'(mag_w(po.x)) * PROD_W'(zm);
      nxa_r[1] <= PROD_W'(mag_w(po.y)) * PROD_W'(zm);
      nxa_r[2] <= PROD_W'(mag_w(hom.zh1)) * PROD_W'(zm);
      a1_r.fault <= po.fault;
      a1_r.wneg  <= wneg_a;
      a1_r.sgn   <= {po.p0[PSUM_W-1] ^ zneg ^ wneg_a,
                     po.p1[PSUM_W-1] ^ zneg ^ wneg_a,
                     po.x[WORD_BITS-1] ^ zneg ^ wneg_a,
                     po.y[WORD_BITS-1] ^ zneg ^ wneg_a,
                     hom.zh1[WORD_BITS-1] ^ zneg ^ wneg_a};
      a1_r.x     <= po.x;
      a1_r.y     <= po.y;
      a1_r.den   <= wm;
    end
  end

  // ---- A2: assemble full numerators
  logic [NUM_W-1:0] numa_r [NA];
  sb_a_t            a2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) a2_r.valid <= 1'b0;
    else if (en) a2_r.valid <= a1_r.valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      numa_r[4] <= (NUM_W'(phi_r[0]) << WORD_BITS) + NUM_W'(plo_r[0]);
      numa_r[3] <= (NUM_W'(phi_r[1]) << WORD_BITS) + NUM_W'(plo_r[1]);
      numa_r[2] <= NUM_W'(nxa_r[0]);
      numa_r[1] <= NUM_W'(nxa_r[1]);
      numa_r[0] <= NUM_W'(nxa_r[2]);
      a2_r.fault <= a1_r.fault;
      a2_r.wneg  <= a1_r.wneg;
      a2_r.sgn   <= a1_r.sgn;
      a2_r.x     <= a1_r.x;
      a2_r.y     <= a1_r.y;
      a2_r.den   <= a1_r.den;
    end
  end

  // ---- divider bank A: u, v, xs, ys, hs (lane 4 down to 0)
  logic [WORD_BITS-1:0] qa [NA];
  logic                 oa [NA];
  sb_a_t                sba_r [DIV_LAT];

  for (genvar i = 0; i < NA; i++) begin : g_diva
    hppj_div u_div (
      .clk (clk),
      .en  (en),
      .num (numa_r[i]),
      .den (a2_r.den),
      .quo (qa[i]),
      .ovf (oa[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DIV_LAT; k++) sba_r[k].valid <= 1'b0;
    end else if (en) begin
      sba_r[0].valid <= a2_r.valid;
      for (int k = 1; k < DIV_LAT; k++) sba_r[k].valid <= sba_r[k-1].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sba_r[0].fault <= a2_r.fault;
      sba_r[0].wneg  <= a2_r.wneg;
      sba_r[0].sgn   <= a2_r.sgn;
      sba_r[0].x     <= a2_r.x;
      sba_r[0].y     <= a2_r.y;
      sba_r[0].den   <= a2_r.den;
      for (int k = 1; k < DIV_LAT; k++) begin
        sba_r[k].fault <= sba_r[k-1].fault;
        sba_r[k].wneg  <= sba_r[k-1].wneg;
        sba_r[k].sgn   <= sba_r[k-1].sgn;
        sba_r[k].x     <= sba_r[k-1].x;
        sba_r[k].y     <= sba_r[k-1].y;
        sba_r[k].den   <= sba_r[k-1].den;
      end
    end
  end

  // ---- A3: saturate first bank
  sb_a_t a3_r;
  word_t u_r, v_r, xs_r, ys_r, hs_r;
  sb_a_t sba_o;

  assign sba_o = sba_r[DIV_LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) a3_r.valid <= 1'b0;
    else if (en) a3_r.valid <= sba_o.valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u_r  <= sat_q(qa[4], oa[4], sba_o.sgn[4]);
      v_r  <= sat_q(qa[3], oa[3], sba_o.sgn[3]);
      xs_r <= sat_q(qa[2], oa[2], sba_o.sgn[2]);
      ys_r <= sat_q(qa[1], oa[1], sba_o.sgn[1]);
      hs_r <= sat_q(qa[0], oa[0], sba_o.sgn[0]);
      a3_r.fault <= sba_o.fault;
      a3_r.wneg  <= sba_o.wneg;
      a3_r.sgn   <= sba_o.sgn;
      a3_r.x     <= sba_o.x;
      a3_r.y     <= sba_o.y;
      a3_r.den   <= sba_o.den;
    end
  end

  // ---- B1: -a*u and -a*v numerators
  logic [NUM_W-1:0] numb_r [NB];
  logic [DEN_W-1:0] denb_r;
  sb_b_t            b1_r;
  logic             nx, ny, nh, nu, nv, nw;

  always_comb begin
    nx = a3_r.x[WORD_BITS-1];
    ny = a3_r.y[WORD_BITS-1];
    nh = hom.zh1[WORD_BITS-1];
    nu = u_r[WORD_BITS-1];
    nv = v_r[WORD_BITS-1];
    nw = ~a3_r.wneg;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) b1_r.valid <= 1'b0;
    else if (en) b1_r.valid <= a3_r.valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      numb_r[5] <= NUM_W'(PROD_W'(mag_w(a3_r.x)) * PROD_W'(mag_w(u_r)));
      numb_r[4] <= NUM_W'(PROD_W'(mag_w(a3_r.y)) * PROD_W'(mag_w(u_r)));
      numb_r[3] <= NUM_W'(PROD_W'(mag_w(hom.zh1)) * PROD_W'(mag_w(u_r)));
      numb_r[2] <= NUM_W'(PROD_W'(mag_w(a3_r.x)) * PROD_W'(mag_w(v_r)));
      numb_r[1] <= NUM_W'(PROD_W'(mag_w(a3_r.y)) * PROD_W'(mag_w(v_r)));
      numb_r[0] <= NUM_W'(PROD_W'(mag_w(hom.zh1)) * PROD_W'(mag_w(v_r)));
      denb_r    <= a3_r.den;
      b1_r.fault <= a3_r.fault;
      b1_r.sgn   <= {nx ^ nu ^ nw, ny ^ nu ^ nw, nh ^ nu ^ nw,
                     nx ^ nv ^ nw, ny ^ nv ^ nw, nh ^ nv ^ nw};
      b1_r.u     <= u_r;
      b1_r.v     <= v_r;
      b1_r.xs    <= xs_r;
      b1_r.ys    <= ys_r;
      b1_r.hs    <= hs_r;
    end
  end

  // ---- divider bank B
  logic [WORD_BITS-1:0] qb [NB];
  logic                 ob [NB];
  sb_b_t                sbb_r [DIV_LAT];

  for (genvar i = 0; i < NB; i++) begin : g_divb
    hppj_div u_div (
      .clk (clk),
      .en  (en),
      .num (numb_r[i]),
      .den (denb_r),
      .quo (qb[i]),
      .ovf (ob[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DIV_LAT; k++) sbb_r[k].valid <= 1'b0;
    end else if (en) begin
      sbb_r[0].valid <= b1_r.valid;
      for (int k = 1; k < DIV_LAT; k++) sbb_r[k].valid <= sbb_r[k-1].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sbb_r[0].fault <= b1_r.fault;
      sbb_r[0].sgn   <= b1_r.sgn;
      sbb_r[0].u     <= b1_r.u;
      sbb_r[0].v     <= b1_r.v;
      sbb_r[0].xs    <= b1_r.xs;
      sbb_r[0].ys    <= b1_r.ys;
      sbb_r[0].hs    <= b1_r.hs;
      for (int k = 1; k < DIV_LAT; k++) begin
        sbb_r[k].fault <= sbb_r[k-1].fault;
        sbb_r[k].sgn   <= sbb_r[k-1].sgn;
        sbb_r[k].u     <= sbb_r[k-1].u;
        sbb_r[k].v     <= sbb_r[k-1].v;
        sbb_r[k].xs    <= sbb_r[k-1].xs;
        sbb_r[k].ys    <= sbb_r[k-1].ys;
        sbb_r[k].hs    <= sbb_r[k-1].hs;
      end
    end
  end

  // ---- B2: saturate, fault masking
  sb_b_t     sbb_o;
  out_item_t res_nxt;
  out_item_t res_r;
  logic      res_valid_r;

  assign sbb_o = sbb_r[DIV_LAT-1];

  always_comb begin
    res_nxt.proj_u = sbb_o.u;
    res_nxt.proj_v = sbb_o.v;
    res_nxt.jac_xs = sbb_o.xs;
    res_nxt.jac_ys = sbb_o.ys;
    res_nxt.jac_hs = sbb_o.hs;
    res_nxt.jac_xu = sat_q(qb[5], ob[5], sbb_o.sgn[5]);
    res_nxt.jac_yu = sat_q(qb[4], ob[4], sbb_o.sgn[4]);
    res_nxt.jac_hu = sat_q(qb[3], ob[3], sbb_o.sgn[3]);
    res_nxt.jac_xv = sat_q(qb[2], ob[2], sbb_o.sgn[2]);
    res_nxt.jac_yv = sat_q(qb[1], ob[1], sbb_o.sgn[1]);
    res_nxt.jac_hv = sat_q(qb[0], ob[0], sbb_o.sgn[0]);
    res_nxt.divide_fault = 1'b0;
    if (sbb_o.fault) begin
      res_nxt = '0;
      res_nxt.divide_fault = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) res_valid_r <= 1'b0;
    else if (en) res_valid_r <= sbb_o.valid;
  end

  always_ff @(posedge clk) begin
    if (en) res_r <= res_nxt;
  end

  // ---- two-entry output buffer; pipeline advances unless it is full
  out_item_t ent_r [2];
  logic [1:0] cnt_r;
  logic       push, pop;

  assign en        = (cnt_r != 2'd2);
  assign in_stall  = ~en;
  assign push      = en & res_valid_r;
  assign out_valid = (cnt_r != 2'd0);
  assign pop       = out_valid & ~out_stall;
  assign out_data  = ent_r[0];

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= 2'd0;
    else cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (push && cnt_r == 2'd1) ent_r[0] <= res_r;
      else ent_r[0] <= ent_r[1];
      if (push && cnt_r == 2'd2) ent_r[1] <= res_r;
    end else if (push) begin
      if (cnt_r == 2'd0) ent_r[0] <= res_r;
      else ent_r[1] <= res_r;
    end
  end

  // ---- checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("output buffer count out of range");

  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.divide_fault |->
      out_data.proj_u == '0 && out_data.proj_v == '0 && out_data.jac_hv == '0)
    else $error("fault result carries nonzero data");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd2 && !pop |=> cnt_r == 2'd2)
    else $error("full buffer changed without a pop");

  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(res_valid_r))
    else $error("pipeline moved while frozen");

endmodule

/* rtl/core/hppj_proj.sv */
// Two-stage homogeneous transform: nine products, then floor-shifted row sums.
module hppj_proj (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  hppj_pkg::in_item_t   in_data,
  input  hppj_pkg::hom_t       hom,
  output hppj_pkg::proj_out_t  po
);
  import hppj_pkg::*;

  logic signed [PROD_W-1:0] prod_r [9];
  logic                     v1_r;
  word_t                    x1_r;
  word_t                    y1_r;
  proj_out_t                po_r;
  logic signed [PROD_W-1:0] sh [9];
  logic signed [PSUM_W-1:0] p0_nxt, p1_nxt, w_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r       <= 1'b0;
      po_r.valid <= 1'b0;
    end else if (en) begin
      v1_r       <= in_valid;
      po_r.valid <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r[0] <= smul(hom.h00, in_data.point_x);
      prod_r[1] <= smul(hom.h01, in_data.point_y);
      prod_r[2] <= smul(hom.h02, hom.zh1);
      prod_r[3] <= smul(hom.h10, in_data.point_x);
      prod_r[4] <= smul(hom.h11, in_data.point_y);
      prod_r[5] <= smul(hom.h12, hom.zh1);
      prod_r[6] <= smul(hom.h20, in_data.point_x);
      prod_r[7] <= smul(hom.h21, in_data.point_y);
      prod_r[8] <= smul(hom.h22, hom.zh1);
      x1_r      <= in_data.point_x;
      y1_r      <= in_data.point_y;
      po_r.x    <= x1_r;
      po_r.y    <= y1_r;
      po_r.p0   <= p0_nxt;
      po_r.p1   <= p1_nxt;
      po_r.w    <= w_nxt;
      po_r.fault <= (w_nxt == '0);
    end
  end

  // arithmetic shift rounds toward minus infinity
  always_comb begin
    for (int k = 0; k < 9; k++) sh[k] = prod_r[k] >>> FRAC_BITS;
    p0_nxt = PSUM_W'(sh[0]) + PSUM_W'(sh[1]) + PSUM_W'(sh[2]);
    p1_nxt = PSUM_W'(sh[3]) + PSUM_W'(sh[4]) + PSUM_W'(sh[5]);
    w_nxt  = PSUM_W'(sh[6]) + PSUM_W'(sh[7]) + PSUM_W'(sh[8]);
  end

  assign po = po_r;

endmodule

/* rtl/core/hppj_div.sv */
// Pipelined restoring divider: overflow check, then one quotient bit per stage.
module hppj_div (
  input  logic                          clk,
  input  logic                          en,
  input  logic [hppj_pkg::NUM_W-1:0]    num,
  input  logic [hppj_pkg::DEN_W-1:0]    den,
  output logic [hppj_pkg::WORD_BITS-1:0] quo,
  output logic                          ovf
);
  import hppj_pkg::*;

  logic [DEN_W-1:0]     rem_r [DIV_LAT];
  logic [WORD_BITS-1:0] lo_r  [DIV_LAT];
  logic [WORD_BITS-1:0] q_r   [DIV_LAT];
  logic [DEN_W-1:0]     den_r [DIV_LAT];
  logic                 ovf_r [DIV_LAT];

  // quotient must fit in a word, else ovf is set and sat_q saturates it downstream
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= num[NUM_W-1:WORD_BITS];
      lo_r[0]  <= num[WORD_BITS-1:0];
      q_r[0]   <= '0;
      den_r[0] <= den;
      ovf_r[0] <= (num[NUM_W-1:WORD_BITS] >= den);
    end
  end

  for (genvar k = 1; k < DIV_LAT; k++) begin : g_step
    logic [DEN_W:0] t;
    logic [DEN_W:0] diff;
    logic           ge;
    assign t    = {rem_r[k-1], lo_r[k-1][WORD_BITS-1]};
    assign ge   = (t >= {1'b0, den_r[k-1]});
    assign diff = t - {1'b0, den_r[k-1]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? diff[DEN_W-1:0] : t[DEN_W-1:0];
        lo_r[k]  <= {lo_r[k-1][WORD_BITS-2:0], 1'b0};
        q_r[k]   <= {q_r[k-1][WORD_BITS-2:0], ge};
        den_r[k] <= den_r[k-1];
        ovf_r[k] <= ovf_r[k-1];
      end
    end
  end

  assign quo = q_r[DIV_LAT-1];
  assign ovf = ovf_r[DIV_LAT-1];

endmodule

/* tb/tb.sv */
// Testbench for the homography point projection block, with checking against a built-in predictor.
module tb;
  import hppj_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;
  localparam int DRAIN_CYCLES = 100;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  logic [63:0] hom_regs [6];
  out_item_t pending_results[$];
  int mismatches = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  event hold_go;
  logic hold_on = 1'b0;

  homography_point_project_jacobian u_top (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // long receiver hold, counted here
  always begin
    @(hold_go);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on <= 1'b0;
  end

  function automatic logic [63:0] mag64(input logic signed [63:0] a);
    return a < 0 ? 64'(-a) : 64'(a);
  endfunction

  // sat(+-a*b/w), quotient truncated toward zero before the sign is applied
  function automatic word_t scaled_quot(input logic signed [63:0] a, input logic signed [63:0] b,
                                        input logic signed [63:0] w, input bit neg);
    bit s;
    logic [127:0] prod;
    logic [127:0] q;
    logic [127:0] lim;
    s = ((a < 0) != (b < 0)) != ((w < 0) != neg);
    prod = 128'(mag64(a)) * 128'(mag64(b));
    q = prod / 128'(mag64(w));
    lim = s ? 128'h8000_0000 : 128'h7fff_ffff;
    if (q > lim) q = lim;
    return s ? word_t'(-q[31:0]) : word_t'(q[31:0]);
  endfunction

  function automatic logic signed [63:0] fx_mul(input word_t a, input word_t b);
    logic signed [63:0] ea;
    logic signed [63:0] eb;
    ea = 64'(a);
    eb = 64'(b);
    return (ea * eb) >>> FRAC_BITS;
  endfunction

  function automatic out_item_t project_point(input in_item_t pt);
    out_item_t r;
    word_t h00, h01, h02, h10, h11, h12, h20, h21, h22, zh1, zh2, u, v;
    logic signed [63:0] p0, p1, w, x, y, z1;
    {h00, h01} = hom_regs[REG_H00_H01];
    {h02, h10} = hom_regs[REG_H02_H10];
    {h11, h12} = hom_regs[REG_H11_H12];
    {h20, h21} = hom_regs[REG_H20_H21];
    {h22, zh1} = hom_regs[REG_H22_SCALE_IN];
    zh2 = hom_regs[REG_SCALE_OUT][31:0];
    p0 = fx_mul(h00, pt.point_x) + fx_mul(h01, pt.point_y) + fx_mul(h02, zh1);
    p1 = fx_mul(h10, pt.point_x) + fx_mul(h11, pt.point_y) + fx_mul(h12, zh1);
    w = fx_mul(h20, pt.point_x) + fx_mul(h21, pt.point_y) + fx_mul(h22, zh1);
    r = '0;
    if (w == 0) begin
      r.divide_fault = 1'b1;
      return r;
    end
    x = 64'(pt.point_x);
    y = 64'(pt.point_y);
    z1 = 64'(zh1);
    u = scaled_quot(p0, 64'(zh2), w, 1'b0);
    v = scaled_quot(p1, 64'(zh2), w, 1'b0);
    r.proj_u = u;
    r.proj_v = v;
    r.jac_xs = scaled_quot(x, 64'(zh2), w, 1'b0);
    r.jac_ys = scaled_quot(y, 64'(zh2), w, 1'b0);
    r.jac_hs = scaled_quot(z1, 64'(zh2), w, 1'b0);
    r.jac_xu = scaled_quot(x, 64'(u), w, 1'b1);
    r.jac_yu = scaled_quot(y, 64'(u), w, 1'b1);
    r.jac_hu = scaled_quot(z1, 64'(u), w, 1'b1);
    r.jac_xv = scaled_quot(x, 64'(v), w, 1'b1);
    r.jac_yv = scaled_quot(y, 64'(v), w, 1'b1);
    r.jac_hv = scaled_quot(z1, 64'(v), w, 1'b1);
    return r;
  endfunction

  task automatic check_word(input string name, input logic [31:0] e, input logic [31:0] a);
    if (e !== a) begin
      mismatches++;
      $display("%0t %s mismatch: expected %h actual %h", $time, name, e, a);
    end
  endtask

  // result checker and receiver stall
  always @(posedge clk) begin
    out_item_t e;
    if (hold_on) begin
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t unexpected result: expected none actual %h", $time, out_data);
      end else begin
        e = pending_results.pop_front();
        check_word("proj_u", e.proj_u, out_data.proj_u);
        check_word("proj_v", e.proj_v, out_data.proj_v);
        check_word("jac_xs", e.jac_xs, out_data.jac_xs);
        check_word("jac_ys", e.jac_ys, out_data.jac_ys);
        check_word("jac_hs", e.jac_hs, out_data.jac_hs);
        check_word("jac_xu", e.jac_xu, out_data.jac_xu);
        check_word("jac_yu", e.jac_yu, out_data.jac_yu);
        check_word("jac_hu", e.jac_hu, out_data.jac_hu);
        check_word("jac_xv", e.jac_xv, out_data.jac_xv);
        check_word("jac_yv", e.jac_yv, out_data.jac_yv);
        check_word("jac_hv", e.jac_hv, out_data.jac_hv);
        check_word("divide_fault", 32'(e.divide_fault), 32'(out_data.divide_fault));
      end
    end
  end

  // valid stays high after acceptance until the next request or a drain takes over
  task automatic send_point(input word_t x, input word_t y);
    in_item_t pt;
    pt.point_x = x;
    pt.point_y = y;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= pt;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(project_point(pt));
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx <= REG_SCALE_OUT)
      hom_regs[idx] = (idx == REG_SCALE_OUT) ? {32'h0, val[31:0]} : val;
  endtask

  function automatic word_t small_fx();
    // mostly within +-4.0, sometimes any value
    if ($urandom_range(9) == 0) return word_t'($urandom);
    return word_t'($signed($urandom_range(19'h7ffff)) - 32'sd262144);
  endfunction

  function automatic word_t rand_point();
    case ($urandom_range(5))
      0: return word_t'($urandom);
      1: return $urandom_range(1) ? 32'sh7fff_ffff : 32'sh8000_0000;
      default: return word_t'($signed($urandom_range(24'hffffff)) - 32'sd8388608);
    endcase
  endfunction

  task automatic load_matrix(input word_t m [11]);
    write_reg(REG_H00_H01, {m[0], m[1]});
    write_reg(REG_H02_H10, {m[2], m[3]});
    write_reg(REG_H11_H12, {m[4], m[5]});
    write_reg(REG_H20_H21, {m[6], m[7]});
    write_reg(REG_H22_SCALE_IN, {m[8], m[9]});
    write_reg(REG_SCALE_OUT, {$urandom, m[10]});
  endtask

  task automatic random_matrix();
    word_t m [11];
    foreach (m[i]) m[i] = small_fx();
    case ($urandom_range(7))
      0: begin m[6] = 0; m[7] = 0; m[8] = 0; end   // w always zero
      1: m[10] = $urandom_range(1) ? 32'sh7fff_ffff : 32'sh8000_0000;
      2: begin m[6] = 0; m[7] = 0; end             // affine
      default: ;
    endcase
    load_matrix(m);
  endtask

  task automatic test_identity_extremes();
    word_t pts [10] = '{32'sh0, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh1_0000, -32'sh1_0000,
                        32'sh1, -32'sh1, 32'sh5555_5555, 32'shaaaa_aaaa, 32'sh0000_8000};
    for (int i = 0; i < 10; i++) send_point(pts[i], pts[9 - i]);
    wait_drain();
  endtask

  task automatic test_special_cfg();
    word_t m [11];
    // zero divisor
    m = '{32'sh1_0000, 0, 0, 0, 32'sh1_0000, 0, 0, 0, 0, 32'sh1_0000, 32'sh1_0000};
    load_matrix(m);
    send_point(32'sh1234_5678, -32'sh10);
    send_point(0, 0);
    wait_drain();
    // tiny w with large scale: saturation both ways
    m = '{32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff,
          32'sh8000_0000, 0, 0, 32'sh1, 32'sh1_0000, 32'sh7fff_ffff};
    load_matrix(m);
    send_point(32'sh7fff_ffff, 32'sh8000_0000);
    send_point(32'sh8000_0000, 32'sh7fff_ffff);
    wait_drain();
    m = '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
          32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
          32'sh8000_0000};
    load_matrix(m);
    send_point(32'sh8000_0000, 32'sh8000_0000);
    send_point(32'sh7fff_ffff, 32'sh1);
    wait_drain();
    // unknown index must leave the registers alone
    write_reg(REG_UNUSED, {$urandom, $urandom});
    write_reg(REG_UNUSED_HI, 64'h0);
    send_point(32'sh2_0000, -32'sh3_0000);
    send_point(32'sh7fff_ffff, 32'sh7fff_ffff);
    wait_drain();
  endtask

  task automatic test_random_phase(input int n_cfg, input int per_cfg);
    for (int c = 0; c < n_cfg; c++) begin
      random_matrix();
      for (int i = 0; i < per_cfg; i++) send_point(rand_point(), rand_point());
      wait_drain();
    end
  endtask

  task automatic test_backpressure();
    random_matrix();
    -> hold_go;
    for (int i = 0; i < 150; i++) send_point(rand_point(), rand_point());
    // sender stops until all results are back
    wait_drain();
    for (int i = 0; i < 20; i++) send_point(rand_point(), rand_point());
    wait_drain();
  endtask

  initial begin
    hom_regs[REG_H00_H01] = RST_H00_H01;
    hom_regs[REG_H02_H10] = RST_H02_H10;
    hom_regs[REG_H11_H12] = RST_H11_H12;
    hom_regs[REG_H20_H21] = RST_H20_H21;
    hom_regs[REG_H22_SCALE_IN] = RST_H22_SCALE_IN;
    hom_regs[REG_SCALE_OUT] = 64'(RST_SCALE_OUT);
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_identity_extremes();
    test_special_cfg();
    send_idle_pct = 25;
    recv_idle_pct = 46;
    test_random_phase(8, 50);
    send_idle_pct = 46;
    recv_idle_pct = 25;
    test_random_phase(8, 50);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_phase(8, 50);
    test_backpressure();
    wait_drain();
    if (mismatches == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
